// File: rtl/ctp_pkg.sv
// Convolution tiling planner: shared widths, defaults and transaction types.
// No dependencies; every other file in rtl/ uses this package.
package ctp_pkg;

    // Input and result field widths
    localparam int C1_W    = 9;
    localparam int K1_W    = 9;
    localparam int P_W     = 11;
    localparam int Q_W     = 11;
    localparam int R_W     = 4;
    localparam int S_W     = 4;
    localparam int ST_W    = 3;
    localparam int SPLIT_W = 7;
    localparam int TILE_W  = 9;
    localparam int CYC_W   = 48;

    // Internal widths
    localparam int RS_W    = 8;   // kern_rows * kern_cols
    localparam int WIN_W   = 14;  // input window width
    localparam int X2_W    = 18;  // kern_rows * window
    localparam int P2_W    = 11;  // row tiles
    localparam int BLK_W   = 40;  // block cost

    // Saturating divider: 9 quotient bits, 3 bits per stage
    localparam int QUO_W   = 9;
    localparam int DIV_LAT = 3;
    localparam int DIV_SPS = 3;

    localparam int LANE_LAT = 6 + DIV_LAT;

    localparam int MIN_COLS        = 16;
    localparam int LANES_PER_GROUP = 8;

    localparam logic [CYC_W-1:0] CYC_MAX = '1;

    localparam int PE_COUNT_DEF         = 8;
    localparam int WEIGHT_BUF_DEPTH_DEF = 256;
    localparam int ACT_BUF_DEPTH_DEF    = 2048;
    localparam int MAX_OUT_COLS_DEF     = 128;
    localparam int TILE_ROWS_DEF        = 8;
    localparam int ACT_PORTS_DEF        = 4;

    // Layer geometry shared by all splits
    typedef struct packed {
        logic [C1_W-1:0]  c1;
        logic [K1_W-1:0]  k1;
        logic [Q_W-1:0]   q;
        logic [Q_W-1:0]   qb;
        logic [P2_W-1:0]  p2;
        logic [R_W-1:0]   r;
        logic [RS_W-1:0]  rs;
        logic [WIN_W-1:0] win;
    } t_geom;

    // Scored split
    typedef struct packed {
        logic               ok;
        logic [SPLIT_W-1:0] kp;
        logic [SPLIT_W-1:0] cp;
        logic [TILE_W-1:0]  tile;
        logic [CYC_W-1:0]   cyc;
    } t_cand;

endpackage

// File: rtl/ctp_div.sv
// Pipelined restoring divider with a saturating 9-bit quotient.
// Depends on ctp_pkg. Accepts one division per cycle.
module ctp_div #(
    parameter int NW = 17,
    parameter int DW = 8
) (
    input  logic                      i_clk,
    input  logic [NW-1:0]             i_num,
    input  logic [DW-1:0]             i_den,
    output logic [ctp_pkg::QUO_W-1:0] o_quo
);

    localparam int QW  = ctp_pkg::QUO_W;
    localparam int NS  = ctp_pkg::DIV_LAT;
    localparam int SPS = ctp_pkg::DIV_SPS;
    localparam int W   = NW + DW + QW;

    logic [NW-1:0] r_rem [NS];
    logic [QW-1:0] r_quo [NS];
    logic [DW-1:0] r_den [NS];

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_stage
            logic [NW-1:0] w_rem_in;
            logic [QW-1:0] w_quo_in;
            logic [DW-1:0] w_den_in;
            logic [NW-1:0] n_rem;
            logic [QW-1:0] n_quo;

            if (g == 0) begin : g_first
                assign w_rem_in = i_num;
                assign w_quo_in = '0;
                assign w_den_in = i_den;
            end else begin : g_next
                assign w_rem_in = r_rem[g-1];
                assign w_quo_in = r_quo[g-1];
                assign w_den_in = r_den[g-1];
            end

            // quotient overflow saturates: every step then subtracts
            always_comb begin
                logic [W-1:0]  v_rem;
                logic [W-1:0]  v_trial;
                logic [QW-1:0] v_quo;
                v_rem = W'(w_rem_in);
                v_quo = w_quo_in;
                for (int j = 0; j < SPS; j++) begin
                    v_trial = W'(w_den_in) << (QW - 1 - g * SPS - j);
                    if (v_rem >= v_trial) begin
                        v_rem = v_rem - v_trial;
                        v_quo[QW-1-g*SPS-j] = 1'b1;
                    end
                end
                n_rem = v_rem[NW-1:0];
                n_quo = v_quo;
            end

            always_ff @(posedge i_clk) begin
                r_rem[g] <= n_rem;
                r_quo[g] <= n_quo;
                r_den[g] <= w_den_in;
            end
        end
    endgenerate

    assign o_quo = r_quo[NS-1];

endmodule

// File: rtl/ctp_front.sv
// Front end: registers the layer, derives the shared geometry and the two buffer limits.
// Depends on ctp_pkg and ctp_div.
module ctp_front #(
    parameter int WEIGHT_BUF_DEPTH = ctp_pkg::WEIGHT_BUF_DEPTH_DEF,
    parameter int ACT_BUF_DEPTH    = ctp_pkg::ACT_BUF_DEPTH_DEF,
    parameter int TILE_ROWS        = ctp_pkg::TILE_ROWS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ctp_pkg::C1_W-1:0]  i_chan_groups,
    input  logic [ctp_pkg::K1_W-1:0]  i_lane_groups,
    input  logic [ctp_pkg::P_W-1:0]   i_out_rows,
    input  logic [ctp_pkg::Q_W-1:0]   i_out_cols,
    input  logic [ctp_pkg::R_W-1:0]   i_kern_rows,
    input  logic [ctp_pkg::S_W-1:0]   i_kern_cols,
    input  logic [ctp_pkg::ST_W-1:0]  i_step_size,
    output logic                      o_vld,
    output ctp_pkg::t_geom            o_geom,
    output logic [ctp_pkg::QUO_W-1:0] o_lim_w,
    output logic [ctp_pkg::QUO_W-1:0] o_lim_a
);

    localparam int C1_W  = ctp_pkg::C1_W;
    localparam int K1_W  = ctp_pkg::K1_W;
    localparam int P_W   = ctp_pkg::P_W;
    localparam int Q_W   = ctp_pkg::Q_W;
    localparam int R_W   = ctp_pkg::R_W;
    localparam int S_W   = ctp_pkg::S_W;
    localparam int ST_W  = ctp_pkg::ST_W;
    localparam int RS_W  = ctp_pkg::RS_W;
    localparam int WIN_W = ctp_pkg::WIN_W;
    localparam int X2_W  = ctp_pkg::X2_W;
    localparam int P2_W  = ctp_pkg::P2_W;
    localparam int DL    = ctp_pkg::DIV_LAT;
    localparam int FL    = 4 + DL;
    localparam int WB_W  = $clog2(WEIGHT_BUF_DEPTH + 1);
    localparam int AB_W  = $clog2(ACT_BUF_DEPTH + 1);
    // ceil(p / TILE_ROWS) through an exact reciprocal
    localparam int PN_W  = 12;
    localparam int PK    = 19;
    localparam int PM_W  = 20;
    localparam int PP_W  = PN_W + PM_W;
    localparam int PM    = ((1 << PK) + TILE_ROWS - 1) / TILE_ROWS;

    logic [FL-1:0] r_vld;

    logic [C1_W-1:0] r1_c1;
    logic [K1_W-1:0] r1_k1;
    logic [P_W-1:0]  r1_p;
    logic [Q_W-1:0]  r1_q;
    logic [R_W-1:0]  r1_r;
    logic [S_W-1:0]  r1_s;
    logic [ST_W-1:0] r1_st;

    logic [C1_W-1:0]  r2_c1;
    logic [K1_W-1:0]  r2_k1;
    logic [Q_W-1:0]   r2_q;
    logic [Q_W-1:0]   r2_qb;
    logic [R_W-1:0]   r2_r;
    logic [S_W-1:0]   r2_s;
    logic [RS_W-1:0]  r2_rs;
    logic [WIN_W-1:0] r2_mw;
    logic [PN_W-1:0]  r2_pn;

    logic [C1_W-1:0]  r3_c1;
    logic [K1_W-1:0]  r3_k1;
    logic [Q_W-1:0]   r3_q;
    logic [Q_W-1:0]   r3_qb;
    logic [R_W-1:0]   r3_r;
    logic [RS_W-1:0]  r3_rs;
    logic [WIN_W-1:0] r3_win;
    logic [P2_W-1:0]  r3_p2;

    ctp_pkg::t_geom   r4_geom;
    logic [X2_W-1:0]  r4_x2;
    ctp_pkg::t_geom   r_gd [DL];

    logic [Q_W-1:0]   w_qb;
    logic [PP_W-1:0]  w_pp;

    assign w_qb = (r1_q < Q_W'(ctp_pkg::MIN_COLS)) ? Q_W'(ctp_pkg::MIN_COLS) : r1_q;
    assign w_pp = PP_W'(r2_pn) * PP_W'(PM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FL-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_c1 <= i_chan_groups;
        r1_k1 <= i_lane_groups;
        r1_p  <= i_out_rows;
        r1_q  <= i_out_cols;
        r1_r  <= i_kern_rows;
        r1_s  <= i_kern_cols;
        r1_st <= i_step_size;

        r2_c1 <= r1_c1;
        r2_k1 <= r1_k1;
        r2_q  <= r1_q;
        r2_qb <= w_qb;
        r2_r  <= r1_r;
        r2_s  <= r1_s;
        r2_rs <= RS_W'(r1_r) * RS_W'(r1_s);
        r2_mw <= WIN_W'(w_qb - Q_W'(1)) * WIN_W'(r1_st);
        r2_pn <= PN_W'(r1_p) + PN_W'(TILE_ROWS - 1);

        r3_c1  <= r2_c1;
        r3_k1  <= r2_k1;
        r3_q   <= r2_q;
        r3_qb  <= r2_qb;
        r3_r   <= r2_r;
        r3_rs  <= r2_rs;
        r3_win <= r2_mw + WIN_W'(r2_s);
        r3_p2  <= w_pp[PK +: P2_W];

        r4_geom.c1  <= r3_c1;
        r4_geom.k1  <= r3_k1;
        r4_geom.q   <= r3_q;
        r4_geom.qb  <= r3_qb;
        r4_geom.p2  <= r3_p2;
        r4_geom.r   <= r3_r;
        r4_geom.rs  <= r3_rs;
        r4_geom.win <= r3_win;
        r4_x2       <= X2_W'(r3_r) * X2_W'(r3_win);

        r_gd[0] <= r4_geom;
        for (int i = 1; i < DL; i++) begin
            r_gd[i] <= r_gd[i-1];
        end
    end

    ctp_div #(.NW(WB_W), .DW(RS_W)) u_div_w (
        .i_clk (i_clk),
        .i_num (WB_W'(WEIGHT_BUF_DEPTH)),
        .i_den (r4_geom.rs),
        .o_quo (o_lim_w)
    );

    ctp_div #(.NW(AB_W), .DW(X2_W)) u_div_a (
        .i_clk (i_clk),
        .i_num (AB_W'(ACT_BUF_DEPTH)),
        .i_den (r4_x2),
        .o_quo (o_lim_a)
    );

    assign o_vld  = r_vld[FL-1];
    assign o_geom = r_gd[DL-1];

endmodule

// File: rtl/ctp_lane.sv
// Scores one PE split (kp output-lane PEs, PE_COUNT / kp input-channel PEs).
// Depends on ctp_pkg and ctp_div.
module ctp_lane #(
    parameter int PE_COUNT     = ctp_pkg::PE_COUNT_DEF,
    parameter int KP           = 1,
    parameter int TILE_ROWS    = ctp_pkg::TILE_ROWS_DEF,
    parameter int ACT_PORTS    = ctp_pkg::ACT_PORTS_DEF,
    parameter int MAX_OUT_COLS = ctp_pkg::MAX_OUT_COLS_DEF
) (
    input  logic                      i_clk,
    input  ctp_pkg::t_geom            i_geom,
    input  logic [ctp_pkg::QUO_W-1:0] i_lim_w,
    input  logic [ctp_pkg::QUO_W-1:0] i_lim_a,
    output ctp_pkg::t_cand            o_cand
);

    localparam int C1_W   = ctp_pkg::C1_W;
    localparam int K1_W   = ctp_pkg::K1_W;
    localparam int Q_W    = ctp_pkg::Q_W;
    localparam int R_W    = ctp_pkg::R_W;
    localparam int RS_W   = ctp_pkg::RS_W;
    localparam int WIN_W  = ctp_pkg::WIN_W;
    localparam int P2_W   = ctp_pkg::P2_W;
    localparam int TW     = ctp_pkg::TILE_W;
    localparam int QW     = ctp_pkg::QUO_W;
    localparam int BW     = ctp_pkg::BLK_W;
    localparam int CW     = ctp_pkg::CYC_W;
    localparam int SW     = ctp_pkg::SPLIT_W;
    localparam int CP     = PE_COUNT / KP;
    localparam int BEATS  = (CP + ACT_PORTS - 1) / ACT_PORTS;
    localparam int LKP    = $clog2(KP);
    localparam int PE8    = PE_COUNT * ctp_pkg::LANES_PER_GROUP;
    // cs = c1 / CP through an exact reciprocal
    localparam int CK     = 16;
    localparam int CM_W   = 17;
    localparam int CSP_W  = C1_W + CM_W;
    localparam int CM     = ((1 << CK) + CP - 1) / CP;
    localparam int DOK_W  = 16;
    localparam int KGS_W  = K1_W + 1;
    localparam int PC_W   = 20;
    localparam int M_W    = 17;
    localparam int T1_W   = PC_W + BW;
    localparam int T2A_W  = K1_W + PC_W;
    localparam int M2_W   = 27;
    localparam int T2_W   = T2A_W + M2_W;

    typedef struct packed {
        logic             ok;
        logic [TW-1:0]    cs;
        logic [TW-1:0]    tile;
        logic [RS_W-1:0]  rs;
        logic [K1_W-1:0]  k1;
        logic [P2_W-1:0]  p2;
    } t_ls;

    // L1
    ctp_pkg::t_geom  r1_geom;
    logic [QW-1:0]   r1_lw;
    logic [QW-1:0]   r1_la;
    logic [TW-1:0]   r1_cs;
    // L2
    t_ls             r2_ls;
    logic [R_W-1:0]  r2_r;
    logic [WIN_W-1:0] r2_win;
    logic [Q_W-1:0]  r2_q;
    logic [Q_W-1:0]  r2_qb;
    // block cost chain alongside the divider
    t_ls             r3_ls;
    t_ls             r4_ls;
    t_ls             r5_ls;
    logic [Q_W-1:0]  r3_qb;
    logic [BW-1:0]   r3_a, r3_b, r3_c;
    logic [BW-1:0]   r4_a, r4_b, r4_c;
    logic [BW-1:0]   r5_a, r5_b, r5_c;
    // cost
    logic            r6_ok, r7_ok, r8_ok;
    logic [TW-1:0]   r6_tile, r7_tile, r8_tile;
    logic [BW-1:0]   r6_blk;
    logic [K1_W-1:0] r6_kg;
    logic [PC_W-1:0] r6_kgp;
    logic [PC_W-1:0] r6_pc;
    logic [M_W-1:0]  r6_m;
    logic [T1_W-1:0] r7_t1;
    logic [T2A_W-1:0] r7_t2a;
    logic [M2_W-1:0] r7_m2;
    logic [CW-1:0]   r8_t1c;
    logic [T2_W-1:0] r8_t2;
    ctp_pkg::t_cand  r9_cand;

    logic [CSP_W-1:0] w_csp;
    logic [TW-1:0]    n_tile;
    logic             w_dok;
    logic [QW-1:0]    w_c2;
    logic             w_one;
    logic [KGS_W-1:0] w_kgs;
    logic [K1_W-1:0]  w_kg;
    logic [TW-1:0]    w_tt;
    logic [BW-1:0]    n_blk;
    logic [CW-1:0]    w_t2c;
    logic [CW:0]      w_sum;

    assign w_csp = CSP_W'(i_geom.c1) * CSP_W'(CM);
    assign w_dok = (DOK_W'(r1_cs) * DOK_W'(CP)) == DOK_W'(r1_geom.c1);

    always_comb begin
        n_tile = r1_cs;
        if (r1_lw < n_tile) begin
            n_tile = r1_lw;
        end
        if (r1_la < n_tile) begin
            n_tile = r1_la;
        end
    end

    // c2 = ceil(cs / tile)
    ctp_div #(.NW(TW + 1), .DW(TW)) u_div_c2 (
        .i_clk (i_clk),
        .i_num ((TW + 1)'(r2_ls.cs) + (TW + 1)'(r2_ls.tile) - (TW + 1)'(1)),
        .i_den (r2_ls.tile),
        .o_quo (w_c2)
    );

    assign w_one = (w_c2 == QW'(1));
    assign w_kgs = KGS_W'(r5_ls.k1) + KGS_W'(KP - 1);
    assign w_kg  = K1_W'(w_kgs >> LKP);
    assign w_tt  = w_one ? r5_ls.cs : r5_ls.tile;

    always_comb begin
        n_blk = r5_a;
        if (r5_b > n_blk) begin
            n_blk = r5_b;
        end
        if (r5_c > n_blk) begin
            n_blk = r5_c;
        end
    end

    assign w_t2c = (r8_t2 > T2_W'(ctp_pkg::CYC_MAX)) ? ctp_pkg::CYC_MAX : r8_t2[CW-1:0];
    assign w_sum = (CW + 1)'(r8_t1c) + (CW + 1)'(w_t2c);

    always_ff @(posedge i_clk) begin
        r1_geom <= i_geom;
        r1_lw   <= i_lim_w;
        r1_la   <= i_lim_a;
        r1_cs   <= w_csp[CK +: TW];

        r2_ls.ok   <= w_dok && (r1_geom.rs != '0) && (n_tile != '0)
                      && (r1_geom.q <= Q_W'(MAX_OUT_COLS));
        r2_ls.cs   <= r1_cs;
        r2_ls.tile <= n_tile;
        r2_ls.rs   <= r1_geom.rs;
        r2_ls.k1   <= r1_geom.k1;
        r2_ls.p2   <= r1_geom.p2;
        r2_r       <= r1_geom.r;
        r2_win     <= r1_geom.win;
        r2_q       <= r1_geom.q;
        r2_qb      <= r1_geom.qb;

        r3_ls <= r2_ls;
        r3_qb <= r2_qb;
        r3_a  <= BW'(r2_ls.rs) * BW'(r2_ls.cs);
        r3_b  <= BW'(r2_r) * BW'(r2_win);
        r3_c  <= BW'(r2_q) * BW'(KP * TILE_ROWS);

        r4_ls <= r3_ls;
        r4_a  <= r3_a * BW'(r3_qb);
        r4_b  <= r3_b * BW'(r3_ls.cs);
        r4_c  <= r3_c;

        r5_ls <= r4_ls;
        r5_a  <= r4_a * BW'(TILE_ROWS);
        r5_b  <= r4_b * BW'(TILE_ROWS * BEATS);
        r5_c  <= r4_c;

        r6_ok   <= r5_ls.ok;
        r6_tile <= r5_ls.tile;
        r6_blk  <= n_blk;
        r6_kg   <= w_kg;
        r6_kgp  <= PC_W'(w_kg) * PC_W'(r5_ls.p2);
        r6_pc   <= w_one ? PC_W'(1) : PC_W'(r5_ls.p2) * PC_W'(w_c2);
        r6_m    <= M_W'(r5_ls.rs) * M_W'(w_tt);

        r7_ok   <= r6_ok;
        r7_tile <= r6_tile;
        r7_t1   <= T1_W'(r6_kgp) * T1_W'(r6_blk);
        r7_t2a  <= T2A_W'(r6_kg) * T2A_W'(r6_pc);
        r7_m2   <= M2_W'(r6_m) * M2_W'(PE8);

        r8_ok   <= r7_ok;
        r8_tile <= r7_tile;
        r8_t1c  <= (r7_t1 > T1_W'(ctp_pkg::CYC_MAX)) ? ctp_pkg::CYC_MAX : r7_t1[CW-1:0];
        r8_t2   <= T2_W'(r7_t2a) * T2_W'(r7_m2);

        r9_cand.ok   <= r8_ok;
        r9_cand.kp   <= SW'(KP);
        r9_cand.cp   <= SW'(CP);
        r9_cand.tile <= r8_tile;
        r9_cand.cyc  <= w_sum[CW] ? ctp_pkg::CYC_MAX : w_sum[CW-1:0];
    end

    assign o_cand = r9_cand;

endmodule

// File: rtl/ctp_pick.sv
// Registered tournament over the scored splits; fewest cycles wins, smaller kp on a tie.
// Depends on ctp_pkg. Each tree level is registered, and one output register follows.
module ctp_pick #(
    parameter int PE_COUNT = ctp_pkg::PE_COUNT_DEF,
    parameter int NL       = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  ctp_pkg::t_cand              i_cand [NL],
    output logic                        o_done,
    output logic                        o_plan_valid,
    output logic [ctp_pkg::SPLIT_W-1:0] o_pe_out_split,
    output logic [ctp_pkg::SPLIT_W-1:0] o_pe_in_split,
    output logic [ctp_pkg::TILE_W-1:0]  o_chan_tile,
    output logic [ctp_pkg::CYC_W-1:0]   o_cycle_estimate
);

    localparam int NP = (NL < 2) ? 2 : (1 << $clog2(NL));
    localparam int LV = $clog2(NP);
    localparam int SW = ctp_pkg::SPLIT_W;
    localparam int TW = ctp_pkg::TILE_W;

    // left side holds the smaller kp, so it keeps ties
    function automatic ctp_pkg::t_cand f_better(input ctp_pkg::t_cand a,
                                                input ctp_pkg::t_cand b);
        return (a.ok && (!b.ok || a.cyc <= b.cyc)) ? a : b;
    endfunction

    ctp_pkg::t_cand w_leaf [NP];
    ctp_pkg::t_cand r_node [1:NP-1];
    logic [LV:0]    r_pv;
    logic           r_ok;
    logic [SW-1:0]  r_kp;
    logic [SW-1:0]  r_cp;
    logic [TW-1:0]  r_tile;
    logic [ctp_pkg::CYC_W-1:0] r_cyc;

    genvar gl, gn;
    generate
        for (gl = 0; gl < NP; gl++) begin : g_leaf
            if (gl < NL) begin : g_used
                assign w_leaf[gl] = i_cand[gl];
            end else begin : g_pad
                assign w_leaf[gl] = '0;
            end
        end
        for (gn = 1; gn < NP; gn++) begin : g_node
            if (2 * gn >= NP) begin : g_bottom
                always_ff @(posedge i_clk) begin
                    r_node[gn] <= f_better(w_leaf[2*gn-NP], w_leaf[2*gn+1-NP]);
                end
            end else begin : g_inner
                always_ff @(posedge i_clk) begin
                    r_node[gn] <= f_better(r_node[2*gn], r_node[2*gn+1]);
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else begin
            r_pv <= {r_pv[LV-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok <= r_node[1].ok;
        if (r_node[1].ok) begin
            r_kp   <= r_node[1].kp;
            r_cp   <= r_node[1].cp;
            r_tile <= r_node[1].tile;
            r_cyc  <= r_node[1].cyc;
        end else begin
            r_kp   <= SW'(PE_COUNT);
            r_cp   <= SW'(1);
            r_tile <= TW'(1);
            r_cyc  <= ctp_pkg::CYC_MAX;
        end
    end

    assign o_done           = r_pv[LV];
    assign o_plan_valid     = r_ok;
    assign o_pe_out_split   = r_kp;
    assign o_pe_in_split    = r_cp;
    assign o_chan_tile      = r_tile;
    assign o_cycle_estimate = r_cyc;

endmodule

// File: rtl/conv_tiling_planner.sv
// Top level of the convolution tiling planner: front end, one scoring lane per split, picker.
// Depends on ctp_pkg, ctp_front, ctp_lane and ctp_pick.
//
// Takes one layer description per clock: a transaction is accepted on each edge where start
// is high, and busy never rises. Every transaction yields exactly one result, shown for one
// cycle with o_done high, in the order accepted. The pipeline runs through the front end
// (geometry plus the two buffer-limit dividers), the split lanes (reciprocal division, the
// tile-count divider and the cost multipliers), then the pick tree and its output register.
// The receiver has no way to stall the pipeline, so results must be taken in the cycle they
// appear.
module conv_tiling_planner #(
    parameter int PE_COUNT         = ctp_pkg::PE_COUNT_DEF,
    parameter int WEIGHT_BUF_DEPTH = ctp_pkg::WEIGHT_BUF_DEPTH_DEF,
    parameter int ACT_BUF_DEPTH    = ctp_pkg::ACT_BUF_DEPTH_DEF,
    parameter int MAX_OUT_COLS     = ctp_pkg::MAX_OUT_COLS_DEF,
    parameter int TILE_ROWS        = ctp_pkg::TILE_ROWS_DEF,
    parameter int ACT_PORTS        = ctp_pkg::ACT_PORTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ctp_pkg::C1_W-1:0]    i_chan_groups,
    input  logic [ctp_pkg::K1_W-1:0]    i_lane_groups,
    input  logic [ctp_pkg::P_W-1:0]     i_out_rows,
    input  logic [ctp_pkg::Q_W-1:0]     i_out_cols,
    input  logic [ctp_pkg::R_W-1:0]     i_kern_rows,
    input  logic [ctp_pkg::S_W-1:0]     i_kern_cols,
    input  logic [ctp_pkg::ST_W-1:0]    i_step_size,
    output logic                        o_done,
    output logic                        o_plan_valid,
    output logic [ctp_pkg::SPLIT_W-1:0] o_pe_out_split,
    output logic [ctp_pkg::SPLIT_W-1:0] o_pe_in_split,
    output logic [ctp_pkg::TILE_W-1:0]  o_chan_tile,
    output logic [ctp_pkg::CYC_W-1:0]   o_cycle_estimate
);

    localparam int NL = $clog2(PE_COUNT) + 1;
    localparam int LL = ctp_pkg::LANE_LAT;

    logic                        w_fvld;
    ctp_pkg::t_geom              w_geom;
    logic [ctp_pkg::QUO_W-1:0]   w_lim_w;
    logic [ctp_pkg::QUO_W-1:0]   w_lim_a;
    ctp_pkg::t_cand              w_cand [NL];
    logic [LL-1:0]               r_lv;

    assign busy = 1'b0;

    ctp_front #(
        .WEIGHT_BUF_DEPTH (WEIGHT_BUF_DEPTH),
        .ACT_BUF_DEPTH    (ACT_BUF_DEPTH),
        .TILE_ROWS        (TILE_ROWS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start & ~busy),
        .i_chan_groups (i_chan_groups),
        .i_lane_groups (i_lane_groups),
        .i_out_rows    (i_out_rows),
        .i_out_cols    (i_out_cols),
        .i_kern_rows   (i_kern_rows),
        .i_kern_cols   (i_kern_cols),
        .i_step_size   (i_step_size),
        .o_vld         (w_fvld),
        .o_geom        (w_geom),
        .o_lim_w       (w_lim_w),
        .o_lim_a       (w_lim_a)
    );

    // kp = 1, 2, 4, ...; a kp that does not divide PE_COUNT never qualifies
    genvar gi;
    generate
        for (gi = 0; gi < NL; gi++) begin : g_lane
            localparam int KP = 1 << gi;
            if (PE_COUNT % KP == 0) begin : g_on
                ctp_lane #(
                    .PE_COUNT     (PE_COUNT),
                    .KP           (KP),
                    .TILE_ROWS    (TILE_ROWS),
                    .ACT_PORTS    (ACT_PORTS),
                    .MAX_OUT_COLS (MAX_OUT_COLS)
                ) u_lane (
                    .i_clk   (i_clk),
                    .i_geom  (w_geom),
                    .i_lim_w (w_lim_w),
                    .i_lim_a (w_lim_a),
                    .o_cand  (w_cand[gi])
                );
            end else begin : g_off
                assign w_cand[gi] = '0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv <= '0;
        end else begin
            r_lv <= {r_lv[LL-2:0], w_fvld};
        end
    end

    ctp_pick #(
        .PE_COUNT (PE_COUNT),
        .NL       (NL)
    ) u_pick (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_vld            (r_lv[LL-1]),
        .i_cand           (w_cand),
        .o_done           (o_done),
        .o_plan_valid     (o_plan_valid),
        .o_pe_out_split   (o_pe_out_split),
        .o_pe_in_split    (o_pe_in_split),
        .o_chan_tile      (o_chan_tile),
        .o_cycle_estimate (o_cycle_estimate)
    );

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for conv_tiling_planner: directed and random layer descriptions,
// a built-in split predictor, and a strobe-driven result checker. Depends on ctp_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import ctp_pkg::*;

    localparam int PE_N      = 8;
    localparam int WBUF      = 256;
    localparam int ABUF      = 2048;
    localparam int COLS_MAX  = 128;
    localparam int TROWS     = 8;
    localparam int APORTS    = 4;
    localparam int LATENCY   = 19;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic [C1_W-1:0]  c1;
        logic [K1_W-1:0]  k1;
        logic [P_W-1:0]   p;
        logic [Q_W-1:0]   q;
        logic [R_W-1:0]   r;
        logic [S_W-1:0]   s;
        logic [ST_W-1:0]  st;
    } layer_t;

    typedef struct packed {
        logic               ok;
        logic [SPLIT_W-1:0] kp;
        logic [SPLIT_W-1:0] cp;
        logic [TILE_W-1:0]  tile;
        logic [CYC_W-1:0]   cyc;
    } plan_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [C1_W-1:0]  i_chan_groups = '0;
    logic [K1_W-1:0]  i_lane_groups = '0;
    logic [P_W-1:0]   i_out_rows = '0;
    logic [Q_W-1:0]   i_out_cols = '0;
    logic [R_W-1:0]   i_kern_rows = '0;
    logic [S_W-1:0]   i_kern_cols = '0;
    logic [ST_W-1:0]  i_step_size = '0;
    logic o_done, o_plan_valid;
    logic [SPLIT_W-1:0] o_pe_out_split, o_pe_in_split;
    logic [TILE_W-1:0]  o_chan_tile;
    logic [CYC_W-1:0]   o_cycle_estimate;

    conv_tiling_planner uut (.*);

    always #10 i_clk = ~i_clk;

    layer_t pending_layers[$];
    plan_t  expected_plans[$];
    int     errors = 0;
    int     idle_pct = 0;
    longint cycles = 0;

    function automatic longint unsigned smul(longint unsigned a, longint unsigned b);
        longint unsigned lim;
        lim = {16'h0, CYC_MAX};
        if (a > lim) a = lim;
        if (b > lim) b = lim;
        if (a != 0 && b > lim / a) return lim;
        return a * b;
    endfunction

    function automatic longint unsigned cdiv(longint unsigned a, longint unsigned b);
        return (a + b - 1) / b;
    endfunction

    function automatic plan_t plan_layer(layer_t l);
        plan_t best;
        longint unsigned kp, cp, rs, qb, win, cs, tile, c2, p2, kg, beats, blk, bl, bg;
        longint unsigned t1, t2, cyc, lim;
        bit found;
        lim = {16'h0, CYC_MAX};
        found = 0;
        best = '{ok: 1'b0, kp: PE_N, cp: 1, tile: 1, cyc: CYC_MAX};
        for (kp = 1; kp <= PE_N; kp *= 2) begin
            if (PE_N % kp != 0) continue;
            cp = PE_N / kp;
            if (l.r == 0 || l.s == 0 || l.c1 % cp != 0) continue;
            rs = l.r * l.s;
            qb = (l.q < MIN_COLS) ? MIN_COLS : l.q;
            win = (qb - 1) * l.st + l.s;
            cs = l.c1 / cp;
            tile = cs;
            if (tile > WBUF / rs) tile = WBUF / rs;
            if (tile > ABUF / (l.r * win)) tile = ABUF / (l.r * win);
            if (tile < 1 || l.q > COLS_MAX) continue;
            c2 = cdiv(cs, tile);
            p2 = cdiv(l.p, TROWS);
            kg = cdiv(l.k1, kp);
            beats = cdiv(cp, APORTS);
            blk = smul(smul(smul(TROWS, rs), cs), qb);
            bl = smul(smul(smul(smul(TROWS, l.r), win), cs), beats);
            bg = smul(smul(TROWS, l.q), kp);
            if (bl > blk) blk = bl;
            if (bg > blk) blk = bg;
            t1 = smul(smul(kg, p2), blk);
            t2 = smul(kg, (c2 == 1) ? 1 : smul(p2, c2));
            t2 = smul(t2, PE_N * LANES_PER_GROUP);
            t2 = smul(t2, rs);
            t2 = smul(t2, (c2 == 1) ? cs : tile);
            cyc = t1 + t2;
            if (cyc > lim) cyc = lim;
            if (!found || cyc < best.cyc) begin
                found = 1;
                best = '{ok: 1'b1, kp: kp, cp: cp, tile: tile, cyc: cyc};
            end
        end
        return best;
    endfunction

    function automatic layer_t random_layer();
        layer_t l;
        l = layer_t'({$urandom, $urandom});
        if ($urandom_range(0, 3) != 0) begin
            // mostly legal geometry, channel counts biased toward split-friendly multiples
            l.c1 = ($urandom_range(0, 1) ? 8 * $urandom_range(1, 32) : $urandom_range(1, 256));
            l.k1 = $urandom_range(1, 256);
            l.p = $urandom_range(1, 1024);
            l.q = $urandom_range(0, 3) ? $urandom_range(1, 128) : $urandom_range(1, 1024);
            l.r = $urandom_range(1, 11);
            l.s = $urandom_range(1, 11);
            l.st = $urandom_range(1, 4);
        end
        return l;
    endfunction

    // Driver: one transaction per edge when the sender is not idling
    always @(posedge i_clk) begin
        if (i_rst_n && (!start || !busy)) begin
            if (pending_layers.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                layer_t l;
                l = pending_layers.pop_front();
                expected_plans.push_back(plan_layer(l));
                start <= 1'b1;
                {i_chan_groups, i_lane_groups, i_out_rows, i_out_cols,
                 i_kern_rows, i_kern_cols, i_step_size} <= l;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_done) begin
            if (expected_plans.size() == 0) begin
                $display("%0t: unexpected result valid=%0b kp=%0d", $time, o_plan_valid,
                         o_pe_out_split);
                errors = errors + 1;
            end else begin
                plan_t e;
                e = expected_plans.pop_front();
                if (e.ok !== o_plan_valid)
                    begin $display("%0t: plan_valid exp %0d got %0d", $time, e.ok,
                                   o_plan_valid); errors = errors + 1; end
                if (e.kp !== o_pe_out_split)
                    begin $display("%0t: pe_out_split exp %0d got %0d", $time, e.kp,
                                   o_pe_out_split); errors = errors + 1; end
                if (e.cp !== o_pe_in_split)
                    begin $display("%0t: pe_in_split exp %0d got %0d", $time, e.cp,
                                   o_pe_in_split); errors = errors + 1; end
                if (e.tile !== o_chan_tile)
                    begin $display("%0t: chan_tile exp %0d got %0d", $time, e.tile,
                                   o_chan_tile); errors = errors + 1; end
                if (e.cyc !== o_cycle_estimate)
                    begin $display("%0t: cycle_estimate exp %0h got %0h", $time, e.cyc,
                                   o_cycle_estimate); errors = errors + 1; end
            end
        end
        if (cycles > CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic run_phase(input int pct, input int count);
        idle_pct = pct;
        for (int i = 0; i < count; i++) pending_layers.push_back(random_layer());
        while (pending_layers.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        layer_t l;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // extremes, zero fields, saturation and no-fit cases
        l = '{c1: 256, k1: 256, p: 1024, q: 128, r: 1, s: 1, st: 1};
        pending_layers.push_back(l);
        l = '{c1: 1, k1: 1, p: 1, q: 1, r: 1, s: 1, st: 1};     pending_layers.push_back(l);
        l = '{c1: 8, k1: 8, p: 8, q: 129, r: 3, s: 3, st: 1};   pending_layers.push_back(l);
        l = '{c1: 64, k1: 64, p: 56, q: 56, r: 0, s: 3, st: 1}; pending_layers.push_back(l);
        l = '{c1: 64, k1: 64, p: 56, q: 56, r: 3, s: 0, st: 1}; pending_layers.push_back(l);
        l = '{c1: 0, k1: 64, p: 56, q: 56, r: 3, s: 3, st: 1};  pending_layers.push_back(l);
        l = '{c1: 64, k1: 0, p: 56, q: 56, r: 3, s: 3, st: 1};  pending_layers.push_back(l);
        l = '{c1: 64, k1: 64, p: 0, q: 56, r: 3, s: 3, st: 1};  pending_layers.push_back(l);
        l = '{c1: 64, k1: 64, p: 56, q: 0, r: 3, s: 3, st: 0};  pending_layers.push_back(l);
        l = '{c1: 511, k1: 511, p: 2047, q: 2047, r: 15, s: 15, st: 7};
        pending_layers.push_back(l);
        l = '{c1: 256, k1: 511, p: 2047, q: 128, r: 1, s: 1, st: 7};
        pending_layers.push_back(l);
        l = '{c1: 24, k1: 100, p: 224, q: 112, r: 7, s: 7, st: 2};
        pending_layers.push_back(l);
        l = '{c1: 3, k1: 8, p: 32, q: 16, r: 11, s: 11, st: 4}; pending_layers.push_back(l);
        l = '{c1: 128, k1: 256, p: 7, q: 7, r: 1, s: 1, st: 1}; pending_layers.push_back(l);
        run_phase(0, 0);
        run_phase(0, 400);
        run_phase(77, 350);
        run_phase(0, 400);
        run_phase(27, 400);
        while (expected_plans.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: sim.f
rtl/ctp_pkg.sv
rtl/ctp_div.sv
rtl/ctp_front.sv
rtl/ctp_lane.sv
rtl/ctp_pick.sv
rtl/conv_tiling_planner.sv
tb/sv/testbench.sv
